@@ hw/rtl/rcv_pkg.sv @@
// shared constants, codes and types of the rgb 5x5 convolution block
package rcv_pkg;

   localparam int MAX_WIDTH     = 128;
   localparam int MAX_HEIGHT    = 128;
   localparam int KERNEL_SIZE   = 5;
   localparam int COEF_BITS     = 12;
   localparam int SLOT_BITS     = 12;

   localparam int COORD_BITS    = 7;
   localparam int SIZE_BITS     = 8;
   localparam int CH_BITS       = 8;
   localparam int PIX_BITS      = 3 * CH_BITS;
   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS     = 2 * COORD_BITS;
   localparam int KIDX_BITS     = 3;
   localparam int SHIFT_BITS    = 4;
   localparam int PROD_BITS     = COEF_BITS + CH_BITS + 1;
   localparam int ACC_BITS      = PROD_BITS + 5;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = KERNEL_SIZE * SLOT_BITS;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KERNEL_ROW0,
      CSR_KERNEL_ROW1,
      CSR_KERNEL_ROW2,
      CSR_KERNEL_ROW3,
      CSR_KERNEL_ROW4,
      CSR_SCALE_SHIFT,
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODULO,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/rcv_req_if.sv @@
// request channel: load or compute beat with pixel position and color
interface rcv_req_if;
   import rcv_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [CH_BITS-1:0]    in_red;
   logic [CH_BITS-1:0]    in_green;
   logic [CH_BITS-1:0]    in_blue;

   modport source (output valid, req_type, pos_x, pos_y, in_red, in_green, in_blue,
                   input ready);
   modport sink (input valid, req_type, pos_x, pos_y, in_red, in_green, in_blue,
                 output ready);
endinterface

@@ hw/rtl/rcv_rsp_if.sv @@
// response channel: filtered pixel beat
interface rcv_rsp_if;
   import rcv_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] res_x;
   logic [COORD_BITS-1:0] res_y;
   logic [CH_BITS-1:0]    out_red;
   logic [CH_BITS-1:0]    out_green;
   logic [CH_BITS-1:0]    out_blue;

   modport source (output valid, res_x, res_y, out_red, out_green, out_blue,
                   input ready);
   modport sink (input valid, res_x, res_y, out_red, out_green, out_blue,
                 output ready);
endinterface

@@ hw/rtl/rcv_ram.sv @@
// generic single-port ram with registered read
module rcv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

@@ hw/rtl/rgb_convolution_5x5_wrap_top.sv @@
// top level: frame store and 5x5 rgb convolution with wrap at the frame edges
//
// req_chan carries load and compute beats. a load beat writes one rgb pixel
// into the 128x128 frame store and gives no response. a compute beat names
// a pixel and gives one rsp_chan beat with its filtered color and the
// position as requested. no request is taken while a compute runs; from
// accept to the next accept it steps through bit-serial modulo of the
// position by the frame size, a setup state, reads of the 25 neighbors from
// the single-port frame memory (one neighbor a cycle, which sets the rate),
// the drain of the read and multiply pipeline and the load of the response
// register.
// the response register sits between the two sides: loads and a new compute
// are taken while a response waits; a compute that finishes while the
// previous response is still held waits until rsp_chan takes it.
// csr writes (index 0..4 kernel rows, 5 shift, 6 width, 7 height) are taken
// in any cycle and must happen while the block is idle.
// reset is synchronous; it clears the kernel and shift, sets the frame size
// to 128x128 and empties the response register. the frame store is not
// cleared: every pixel must be loaded before a compute reads it.
module rgb_convolution_5x5_wrap_top (
   input  logic                                clock,
   input  logic                                reset,
   rcv_req_if.sink                             req_chan,
   rcv_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [rcv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rcv_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rcv_pkg::*;

   localparam logic [KIDX_BITS-1:0] KLAST = KIDX_BITS'(KERNEL_SIZE - 1);

   state_type state_ff, state_in;

   logic [CSR_DATA_BITS-1:0] kernel_row_ff [KERNEL_SIZE];
   logic [SHIFT_BITS-1:0]    scale_ff;
   logic [SIZE_BITS-1:0]     width_ff;
   logic [SIZE_BITS-1:0]     height_ff;

   logic [SIZE_BITS-1:0]  w_eff, h_eff;
   logic [COORD_BITS-1:0] wm1, hm1;

   logic [COORD_BITS-1:0] req_x_ff, req_x_in, req_y_ff, req_y_in;
   logic [COORD_BITS-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [2:0]            bit_cnt_ff, bit_cnt_in;
   logic [SIZE_BITS-1:0]  rem_sh_x, rem_sh_y;
   logic [COORD_BITS-1:0] ix_ff, ix_in, iy_ff, iy_in, start_x_ff, start_x_in;
   logic [KIDX_BITS-1:0]  row_ff, row_in, col_ff, col_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [KIDX_BITS-1:0]  rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;
   logic                  mul_vld_ff, mul_vld_in;
   logic signed [PROD_BITS-1:0] prod_ff [3];
   logic signed [PROD_BITS-1:0] prod_in [3];
   logic signed [ACC_BITS-1:0]  acc_ff [3];
   logic signed [ACC_BITS-1:0]  acc_in [3];
   logic signed [COEF_BITS-1:0] coef;
   logic signed [PROD_BITS-1:0] coef_ext;
   logic signed [PROD_BITS-1:0] pix_ext [3];

   logic                  rsp_vld_ff, rsp_vld_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CH_BITS-1:0]    rsp_ch_ff [3];
   logic [CH_BITS-1:0]    rsp_ch_in [3];

   logic                  req_accept;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic [PIX_BITS-1:0]   ram_wdata, ram_rdata;

   function automatic logic [COORD_BITS-1:0] wrap_dec(input logic [COORD_BITS-1:0] v,
                                                      input logic [COORD_BITS-1:0] last);
      return (v == '0) ? last : v - COORD_BITS'(1);
   endfunction

   function automatic logic [COORD_BITS-1:0] wrap_inc(input logic [COORD_BITS-1:0] v,
                                                      input logic [COORD_BITS-1:0] last);
      return (v == last) ? '0 : v + COORD_BITS'(1);
   endfunction

   function automatic logic [CH_BITS-1:0] clamp_ch(input logic signed [ACC_BITS-1:0] sum,
                                                   input logic [SHIFT_BITS-1:0] sh);
      logic signed [ACC_BITS-1:0] shifted;
      shifted = sum >>> sh;
      if (sum < 0) begin
         return '0;
      end else if (shifted > ACC_BITS'(255)) begin
         return '1;
      end
      return shifted[CH_BITS-1:0];
   endfunction

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (width_ff > SIZE_BITS'(MAX_WIDTH)) begin
         w_eff = SIZE_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (height_ff > SIZE_BITS'(MAX_HEIGHT)) begin
         h_eff = SIZE_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      wm1 = COORD_BITS'(w_eff - SIZE_BITS'(1));
      hm1 = COORD_BITS'(h_eff - SIZE_BITS'(1));
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.req_type == REQ_COMPUTE) begin
               state_in = ST_MODULO;
            end
         end
         ST_MODULO: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (row_ff == KLAST && col_ff == KLAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      ram_we         = 1'b0;
      ram_addr       = {iy_ff, ix_ff};
      rd_vld_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ram_we         = req_accept && req_chan.req_type == REQ_LOAD;
            ram_addr       = {req_chan.pos_y, req_chan.pos_x};
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign ram_wdata = {req_chan.in_red, req_chan.in_green, req_chan.in_blue};

   rcv_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // position modulo, neighbor walk
   always_comb begin
      req_x_in   = req_x_ff;
      req_y_in   = req_y_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      bit_cnt_in = bit_cnt_ff;
      ix_in      = ix_ff;
      iy_in      = iy_ff;
      start_x_in = start_x_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rd_row_in  = row_ff;
      rd_col_in  = col_ff;
      rem_sh_x   = {rem_x_ff, req_x_ff[bit_cnt_ff]};
      rem_sh_y   = {rem_y_ff, req_y_ff[bit_cnt_ff]};
      case (state_ff)
         ST_IDLE: begin
            req_x_in   = req_chan.pos_x;
            req_y_in   = req_chan.pos_y;
            rem_x_in   = '0;
            rem_y_in   = '0;
            bit_cnt_in = 3'(COORD_BITS - 1);
         end
         ST_MODULO: begin
            rem_x_in   = (rem_sh_x >= w_eff) ? COORD_BITS'(rem_sh_x - w_eff)
                                             : rem_sh_x[COORD_BITS-1:0];
            rem_y_in   = (rem_sh_y >= h_eff) ? COORD_BITS'(rem_sh_y - h_eff)
                                             : rem_sh_y[COORD_BITS-1:0];
            bit_cnt_in = bit_cnt_ff - 3'(1);
         end
         ST_PREP: begin
            start_x_in = wrap_dec(wrap_dec(rem_x_ff, wm1), wm1);
            ix_in      = wrap_dec(wrap_dec(rem_x_ff, wm1), wm1);
            iy_in      = wrap_dec(wrap_dec(rem_y_ff, hm1), hm1);
            row_in     = '0;
            col_in     = '0;
         end
         ST_SCAN: begin
            if (col_ff == KLAST) begin
               col_in = '0;
               ix_in  = start_x_ff;
               row_in = row_ff + KIDX_BITS'(1);
               iy_in  = wrap_inc(iy_ff, hm1);
            end else begin
               col_in = col_ff + KIDX_BITS'(1);
               ix_in  = wrap_inc(ix_ff, wm1);
            end
         end
         default: begin
            bit_cnt_in = bit_cnt_ff;
         end
      endcase
   end

   // multiply and accumulate
   always_comb begin
      coef       = signed'(kernel_row_ff[rd_row_ff][SLOT_BITS * rd_col_ff +: COEF_BITS]);
      coef_ext   = PROD_BITS'(coef);
      mul_vld_in = rd_vld_ff;
      for (int ch = 0; ch < 3; ch++) begin
         pix_ext[ch] = signed'(PROD_BITS'(ram_rdata[(2 - ch) * CH_BITS +: CH_BITS]));
         prod_in[ch] = coef_ext * pix_ext[ch];
         if (state_ff == ST_PREP) begin
            acc_in[ch] = '0;
         end else if (mul_vld_ff) begin
            acc_in[ch] = acc_ff[ch] + ACC_BITS'(prod_ff[ch]);
         end else begin
            acc_in[ch] = acc_ff[ch];
         end
      end
   end

   // response register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_x_in   = rsp_x_ff;
      rsp_y_in   = rsp_y_ff;
      for (int ch = 0; ch < 3; ch++) begin
         rsp_ch_in[ch] = rsp_ch_ff[ch];
      end
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (state_ff == ST_DONE && (!rsp_vld_ff || rsp_chan.ready)) begin
         rsp_vld_in = 1'b1;
         rsp_x_in   = req_x_ff;
         rsp_y_in   = req_y_ff;
         for (int ch = 0; ch < 3; ch++) begin
            rsp_ch_in[ch] = clamp_ch(acc_ff[ch], scale_ff);
         end
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.res_x     = rsp_x_ff;
   assign rsp_chan.res_y     = rsp_y_ff;
   assign rsp_chan.out_red   = rsp_ch_ff[0];
   assign rsp_chan.out_green = rsp_ch_ff[1];
   assign rsp_chan.out_blue  = rsp_ch_ff[2];

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            kernel_row_ff[r] <= '0;
         end
         scale_ff  <= '0;
         width_ff  <= SIZE_BITS'(MAX_WIDTH);
         height_ff <= SIZE_BITS'(MAX_HEIGHT);
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_KERNEL_ROW0: kernel_row_ff[0] <= csr_wdata;
               CSR_KERNEL_ROW1: kernel_row_ff[1] <= csr_wdata;
               CSR_KERNEL_ROW2: kernel_row_ff[2] <= csr_wdata;
               CSR_KERNEL_ROW3: kernel_row_ff[3] <= csr_wdata;
               CSR_KERNEL_ROW4: kernel_row_ff[4] <= csr_wdata;
               CSR_SCALE_SHIFT: scale_ff         <= csr_wdata[SHIFT_BITS-1:0];
               CSR_FRAME_WIDTH: width_ff         <= csr_wdata[SIZE_BITS-1:0];
               CSR_FRAME_HEIGHT: height_ff       <= csr_wdata[SIZE_BITS-1:0];
               default: scale_ff <= scale_ff;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      req_x_ff   <= req_x_in;
      req_y_ff   <= req_y_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      bit_cnt_ff <= bit_cnt_in;
      ix_ff      <= ix_in;
      iy_ff      <= iy_in;
      start_x_ff <= start_x_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      rd_row_ff  <= rd_row_in;
      rd_col_ff  <= rd_col_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      for (int ch = 0; ch < 3; ch++) begin
         prod_ff[ch]   <= prod_in[ch];
         acc_ff[ch]    <= acc_in[ch];
         rsp_ch_ff[ch] <= rsp_ch_in[ch];
      end
   end

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !rd_vld_ff && !mul_vld_ff)
      else $error("result taken before the multiply pipeline drained");

   a_scan_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> {1'b0, ix_ff} < w_eff && {1'b0, iy_ff} < h_eff &&
                              row_ff <= KLAST && col_ff <= KLAST)
      else $error("neighbor walk left the frame or the kernel");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_no_write_in_compute: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE && !rd_vld_ff)
      else $error("frame store written during a compute");

endmodule
